// ----- hw/rtl/email_address_validator_core_defines.svh -----
// Assertion macros shared by the checker of the address validator.
// Needs signals named clk_i and rst_ni in the module that uses them.
`ifndef EMAIL_ADDRESS_VALIDATOR_CORE_DEFINES_SVH
`define EMAIL_ADDRESS_VALIDATOR_CORE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define EAV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define EAV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/eav_pkg.sv -----
// Types and character constants for the address validator.
// No dependencies; used by the core and by its checker.
package eav_pkg;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'h20;

  localparam logic [1:0] AtNone = 2'd0;
  localparam logic [1:0] AtOne  = 2'd1;
  localparam logic [1:0] AtMany = 2'd2;

  typedef enum logic [2:0] {
    FAULT_OK         = 3'd0,
    FAULT_BLANK      = 3'd1,
    FAULT_WHITESPACE = 3'd2,
    FAULT_AT_COUNT   = 3'd3,
    FAULT_EMPTY_PART = 3'd4,
    FAULT_EDGE_DOT   = 3'd5,
    FAULT_NO_DOT     = 3'd6
  } fault_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } eav_in_t;

  typedef struct packed {
    logic [7:0] lowered_byte;
    logic       byte_kept;
    logic       done_res;
    logic       accepted;
    logic [2:0] fault;
  } eav_out_t;

  typedef struct packed {
    logic       content_started;
    logic       trailing_space_pending;
    logic       space_violation;
    logic [1:0] at_count_sat;
    logic       local_empty;
    logic       domain_first_pending;
    logic       domain_starts_dot;
    logic       domain_has_dot;
    logic       last_was_dot;
    logic       last_was_at;
  } eav_state_t;

  function automatic logic is_trim(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  endfunction

endpackage

// ----- hw/rtl/email_address_validator_core.sv -----
// Streaming e-mail address validator, top level.
// Depends on eav_pkg for payload structs, fault codes and character constants.
//
// Usage: an address enters one byte per transaction on the input channel
// (in_valid_i / in_ready_o, payload in_data_i), its final byte marked by last.
// Every input transaction yields exactly one output transaction on
// out_valid_o / out_ready_i with payload out_data_o: the byte lowercased, a
// kept flag for content bytes and, on the final byte, the verdict (accepted
// and a fault code naming the first rule broken). After a verdict the
// checking state is cleared, so the next byte starts a new address.
// The result passes through two registers on its way out: the input register
// and then the result register. Throughput is one byte per cycle while the
// receiver takes every result; the rule flags are updated by a few gates per
// byte between the two registers. When the receiver stalls, the held result
// stays on the output and the input register takes one more byte only if it
// is empty; after that in_ready_o drops until the result is taken. Reset empties
// both registers and clears the checking state; no address is in progress.
module email_address_validator_core
  import eav_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  eav_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output eav_out_t out_data_o
);

  logic       in_vld_q;
  eav_in_t    in_q;
  logic       out_vld_q;
  eav_out_t   out_q;
  eav_state_t st_q, st_d;
  eav_state_t st_upd;
  eav_out_t   res_d;
  fault_e     fault;
  logic       advance;
  logic       in_take;

  logic [7:0] c;
  logic       c_at, c_dot;

  // The input stage moves on whenever the result register is free or drains.
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  assign c     = in_q.data_byte;
  assign c_at  = (c == ChAt);
  assign c_dot = (c == ChDot);

  always_comb begin
    st_upd = st_q;
    if (is_trim(c)) begin
      if (st_q.content_started) begin
        st_upd.trailing_space_pending = 1'b1;
      end
    end else begin
      if (st_q.trailing_space_pending || (c == ChVt) || (c == ChFf)) begin
        st_upd.space_violation = 1'b1;
      end
      st_upd.trailing_space_pending = 1'b0;
      if (c_at && (st_q.at_count_sat == AtNone)) begin
        st_upd.local_empty          = !st_q.content_started;
        st_upd.domain_first_pending = 1'b1;
      end else if (st_q.domain_first_pending) begin
        st_upd.domain_starts_dot    = c_dot;
        st_upd.domain_first_pending = 1'b0;
      end
      if (c_dot && (st_q.at_count_sat != AtNone)) begin
        st_upd.domain_has_dot = 1'b1;
      end
      if (c_at && (st_q.at_count_sat != AtMany)) begin
        st_upd.at_count_sat = st_q.at_count_sat + 2'd1;
      end
      st_upd.last_was_dot    = c_dot;
      st_upd.last_was_at     = c_at;
      st_upd.content_started = 1'b1;
    end
  end

  // The first rule broken wins, in priority order.
  always_comb begin
    if (!st_upd.content_started) begin
      fault = FAULT_BLANK;
    end else if (st_upd.space_violation) begin
      fault = FAULT_WHITESPACE;
    end else if (st_upd.at_count_sat != AtOne) begin
      fault = FAULT_AT_COUNT;
    end else if (st_upd.local_empty || st_upd.last_was_at) begin
      fault = FAULT_EMPTY_PART;
    end else if (st_upd.domain_starts_dot || st_upd.last_was_dot) begin
      fault = FAULT_EDGE_DOT;
    end else if (!st_upd.domain_has_dot) begin
      fault = FAULT_NO_DOT;
    end else begin
      fault = FAULT_OK;
    end
  end

  always_comb begin
    res_d.lowered_byte = ((c >= ChUpperA) && (c <= ChUpperZ)) ? (c + CaseOffset) : c;
    res_d.byte_kept    = !is_trim(c);
    res_d.done_res     = in_q.last;
    res_d.accepted     = in_q.last && (fault == FAULT_OK);
    res_d.fault        = in_q.last ? fault : FAULT_OK;
    st_d               = in_q.last ? '0 : st_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
        if (in_vld_q) begin
          st_q <= st_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance && in_vld_q) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/eav_checker.sv -----
// Port-level checker for the address validator, bound to the top level.
// Depends on eav_pkg and email_address_validator_core_defines.svh.
`include "email_address_validator_core_defines.svh"

module eav_checker
  import eav_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input eav_out_t out_data_i
);

  logic in_take;
  logic out_stall;
  logic out_mid;
  logic out_quiet;
  logic out_unkept;
  logic out_trim;

  assign in_take    = in_valid_i && in_ready_i;
  assign out_stall  = out_valid_i && !out_ready_i;
  assign out_mid    = out_valid_i && !out_data_i.done_res;
  assign out_quiet  = !out_data_i.accepted && (out_data_i.fault == FAULT_OK);
  assign out_unkept = out_valid_i && !out_data_i.byte_kept;
  assign out_trim   = is_trim(out_data_i.lowered_byte);

  // A stalled result must hold until the transaction completes.
  `EAV_ASSERT(a_out_hold, out_stall |=> out_valid_i && $stable(out_data_i), "output changed")

  // Verdict fields are quiet on every byte but the final one.
  `EAV_ASSERT(a_not_done_quiet, out_mid |-> out_quiet, "verdict shown before final byte")

  // A byte marked as not kept must be one of the trimmed whitespace bytes.
  `EAV_ASSERT(a_unkept_is_trim, out_unkept |-> out_trim, "non-whitespace byte dropped")

  // A new result is always preceded by an input transaction, with the input register between them.
  `EAV_ASSERT(a_rise_latency, $rose(out_valid_i) |-> $past(in_take, 2), "result without input")

endmodule

bind email_address_validator_core eav_checker u_eav_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
